>>> sv/rate_monotonic_task_scheduler_core_defines.svh
// Assertion macros for the rate-monotonic task scheduler core.
`ifndef RATE_MONOTONIC_TASK_SCHEDULER_CORE_DEFINES_SVH
`define RATE_MONOTONIC_TASK_SCHEDULER_CORE_DEFINES_SVH
`ifndef SYNTH
// Clocked assertion, disabled while reset is asserted.
`define RMTS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rmts assertion failed");
// Clocked assertion that also holds during reset.
`define RMTS_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("rmts assertion failed");
`else
`define RMTS_ASSERT(lbl, clk, rstn, prop)
`define RMTS_ASSERT_NR(lbl, clk, prop)
`endif
`endif

>>> sv/rmts_pkg.sv
// Shared types and constants of the rate-monotonic task scheduler.
`timescale 1ns / 1ps
package rmts_pkg;

  localparam int PERIOD_W   = 16;
  localparam int RUN_W      = 16;
  localparam int POWER_W    = 12;
  localparam int HORIZON_W  = 20;
  localparam int COUNT_W    = 4;
  localparam int SLOT_W     = 3;
  localparam int OUT_TIME_W = 20;
  localparam int TASK_OUT_W = 3;
  localparam int SLOT_E_W   = 32;
  localparam int ETOT_W     = 40;
  localparam int ITOT_W     = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 136;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_STEP    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  localparam logic [1:0] KIND_RUN  = 2'd0;
  localparam logic [1:0] KIND_IDLE = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;
  localparam logic [1:0] KIND_ACK  = 2'd3;

  localparam logic [1:0] REG_TASK_COUNT   = 2'd0;
  localparam logic [1:0] REG_HORIZON      = 2'd1;
  localparam logic [1:0] REG_ACTIVE_POWER = 2'd2;
  localparam logic [1:0] REG_IDLE_POWER   = 2'd3;

  localparam logic [COUNT_W-1:0]   TASK_COUNT_RST = 4'd1;
  localparam logic [HORIZON_W-1:0] HORIZON_RST    = 20'd1000;

  typedef struct packed {
    logic clear;
    logic load;
    logic mark_ready;
    logic retire;
  } rmts_tbl_cmd_t;

endpackage

>>> sv/rate_monotonic_task_scheduler_core.sv
// Top level of the non-preemptive rate-monotonic task scheduler core.
// Input stream in_*: in_tuser is the opcode (load, step, restart, no-op),
// in_tdata has slot, period and run time. Each request yields exactly one record
// on out_*: out_tuser is the record kind, out_tdata the times and energies.
// Registers task_count, horizon, active_power and idle_power are written
// on cfg_* (always ready); the user must do so only while no request is in
// flight; the block does not enforce it. Load, restart and no-op requests
// go straight to emit; a step past the horizon check emits a done record.
// A step that runs a task passes the check, the release scan over n active
// tasks, the selection scan over all MAX_TASKS slots, prep, the energy
// multiply, update and emit; an idle step adds a search of the nearest
// release over n tasks. The release, selection and gap scans walk the table
// one entry per cycle through a single shared compare and subtract unit.
// One request is in flight at a time; in_tready is high only while the
// sequencer idles. A finished record waits in the output register while
// the next request is accepted; a stalled receiver holds the sequencer at
// its last step until the register frees. Reset restores the register
// defaults and clears times, release state and totals.
`timescale 1ns / 1ps
`include "rate_monotonic_task_scheduler_core_defines.svh"
module rate_monotonic_task_scheduler_core import rmts_pkg::*; #(
  parameter int MAX_TASKS = 8,
  parameter int TIME_BITS = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // task_slot[2:0], period[18:3], run_time[34:19], zero[39:35]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode[1:0]
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // start_time[19:0], chosen_task[22:20], duration[42:23], slot_energy[74:43],
  // energy_total[114:75], idle_total[134:115], zero[135]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // kind[1:0]
  output logic [1:0]            out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int KEY_W  = PERIOD_W + TIME_BITS;
  localparam int DUR_W  = (TIME_BITS > HORIZON_W) ? TIME_BITS : HORIZON_W;
  localparam int PROD_W = DUR_W + POWER_W;
  localparam int EXT_W  = ((PROD_W > ETOT_W) ? PROD_W : ETOT_W) + 1;
  localparam int REL_W  = ((TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W) + 1;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_REL, S_SEL, S_GAP, S_PREP, S_MUL, S_UPD, S_EMIT
  } state_t;

  state_t state_r;

  logic [COUNT_W-1:0]   task_count_r;
  logic [HORIZON_W-1:0] horizon_r;
  logic [POWER_W-1:0]   active_power_r;
  logic [POWER_W-1:0]   idle_power_r;

  logic [CNT_W-1:0]     cnt_r;
  logic                 found_r;
  logic                 is_idle_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [PERIOD_W-1:0]  best_per_r;
  logic [TIME_BITS-1:0] best_stamp_r;
  logic [RUN_W-1:0]     best_run_r;
  logic [TIME_BITS-1:0] best_rel_r;
  logic [DUR_W-1:0]     target_r;
  logic [DUR_W-1:0]     dur_r;
  logic [PROD_W-1:0]    prod_r;
  logic [TIME_BITS-1:0] cur_r;
  logic [ETOT_W-1:0]    esum_r;
  logic [ITOT_W-1:0]    isum_r;

  logic [1:0]           rec_kind_r;
  logic [TIME_BITS-1:0] rec_start_r;
  logic [IDX_W-1:0]     rec_task_r;
  logic [DUR_W-1:0]     rec_dur_r;
  logic [PROD_W-1:0]    rec_e_r;
  logic                 out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [1:0]           out_user_r;

  logic                 in_acc;
  logic [1:0]           in_op;
  logic [SLOT_W-1:0]    in_slot;
  logic [IDX_W+SLOT_W-1:0] slot_ext;
  logic                 slot_ok;
  logic [CNT_W-1:0]     n_c;
  logic [IDX_W-1:0]     scan_idx;

  rmts_tbl_cmd_t        tbl_cmd;
  logic [IDX_W-1:0]     upd_idx;
  logic [TIME_BITS-1:0] rel_new;
  logic [PERIOD_W-1:0]  rd_period;
  logic [RUN_W-1:0]     rd_run;
  logic [TIME_BITS-1:0] rd_rel;
  logic                 rd_ready;
  logic [TIME_BITS-1:0] rd_stamp;

  logic [KEY_W-1:0]     cmp_a;
  logic [KEY_W-1:0]     cmp_b;
  logic                 cmp_lt;
  logic [KEY_W-1:0]     cmp_diff;

  logic [EXT_W-1:0]     esum_add;
  logic [DUR_W:0]       isum_add;
  logic [REL_W-1:0]     cur_add;
  logic [REL_W-1:0]     rel_add;
  logic [TIME_BITS+OUT_TIME_W-1:0] start_ext;
  logic [IDX_W+TASK_OUT_W-1:0]     task_ext;
  logic [SLOT_E_W-1:0]  slot_e;
  logic                 emit_go;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_op     = in_tuser;
  assign in_slot   = in_tdata[SLOT_W-1:0];
  assign slot_ext  = (IDX_W + SLOT_W)'(in_slot);
  assign slot_ok   = (32'(in_slot) < MAX_TASKS);
  assign scan_idx  = cnt_r[IDX_W-1:0];
  assign cfg_ready = 1'b1;
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    if (32'(task_count_r) > MAX_TASKS) begin
      n_c = CNT_W'(MAX_TASKS);
    end else begin
      n_c = CNT_W'(task_count_r);
    end
  end

  always_comb begin
    tbl_cmd.clear      = in_acc && (in_op == OP_RESTART);
    tbl_cmd.load       = in_acc && (in_op == OP_LOAD) && slot_ok;
    tbl_cmd.mark_ready = (state_r == S_REL) && (cnt_r < n_c) && !rd_ready && !cmp_lt;
    tbl_cmd.retire     = (state_r == S_UPD) && !is_idle_r;
  end

  assign upd_idx = (state_r == S_REL) ? scan_idx : best_idx_r;

  always_comb begin
    rel_add = REL_W'(best_rel_r) + REL_W'(best_per_r);
    rel_new = (rel_add > REL_W'(TMAX)) ? TMAX : rel_add[TIME_BITS-1:0];
  end

  rmts_task_table #(
    .MAX_TASKS (MAX_TASKS),
    .TIME_BITS (TIME_BITS),
    .IDX_W     (IDX_W)
  ) u_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (tbl_cmd),
    .load_idx    (slot_ext[IDX_W-1:0]),
    .load_period (in_tdata[SLOT_W +: PERIOD_W]),
    .load_run    (in_tdata[SLOT_W+PERIOD_W +: RUN_W]),
    .upd_idx     (upd_idx),
    .stamp_val   (cur_r),
    .rel_val     (rel_new),
    .rd_idx      (scan_idx),
    .rd_period   (rd_period),
    .rd_run      (rd_run),
    .rd_rel      (rd_rel),
    .rd_ready    (rd_ready),
    .rd_stamp    (rd_stamp)
  );

  always_comb begin
    unique case (state_r)
      S_CHECK: begin
        cmp_a = KEY_W'(cur_r);
        cmp_b = KEY_W'(horizon_r);
      end
      S_REL: begin
        cmp_a = KEY_W'(cur_r);
        cmp_b = KEY_W'(rd_rel);
      end
      S_SEL: begin
        cmp_a = {rd_period, rd_stamp};
        cmp_b = {best_per_r, best_stamp_r};
      end
      S_GAP: begin
        cmp_a = KEY_W'(rd_rel);
        cmp_b = KEY_W'(best_rel_r);
      end
      S_PREP: begin
        cmp_a = KEY_W'(target_r);
        cmp_b = KEY_W'(cur_r);
      end
      default: begin
        cmp_a = '0;
        cmp_b = '0;
      end
    endcase
  end

  rmts_cmp_sub #(
    .W (KEY_W)
  ) u_cmp (
    .op_a   (cmp_a),
    .op_b   (cmp_b),
    .a_lt_b (cmp_lt),
    .diff   (cmp_diff)
  );

  always_comb begin
    esum_add  = EXT_W'(esum_r) + EXT_W'(prod_r);
    isum_add  = (DUR_W + 1)'(isum_r) + (DUR_W + 1)'(dur_r);
    cur_add   = REL_W'(cur_r) + REL_W'(best_run_r);
    start_ext = (TIME_BITS + OUT_TIME_W)'(rec_start_r);
    task_ext  = (IDX_W + TASK_OUT_W)'(rec_task_r);
    slot_e    = (rec_e_r > PROD_W'({SLOT_E_W{1'b1}})) ? {SLOT_E_W{1'b1}}
                                                      : rec_e_r[SLOT_E_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      task_count_r   <= TASK_COUNT_RST;
      horizon_r      <= HORIZON_RST;
      active_power_r <= '0;
      idle_power_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TASK_COUNT:   task_count_r   <= cfg_data[COUNT_W-1:0];
        REG_HORIZON:      horizon_r      <= cfg_data[HORIZON_W-1:0];
        REG_ACTIVE_POWER: active_power_r <= cfg_data[POWER_W-1:0];
        REG_IDLE_POWER:   idle_power_r   <= cfg_data[POWER_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      is_idle_r   <= 1'b0;
      cur_r       <= '0;
      esum_r      <= '0;
      isum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            rec_kind_r  <= KIND_ACK;
            rec_start_r <= '0;
            rec_task_r  <= '0;
            rec_dur_r   <= '0;
            rec_e_r     <= '0;
            if (in_op == OP_STEP) begin
              state_r <= S_CHECK;
            end else begin
              state_r <= S_EMIT;
            end
            if (in_op == OP_RESTART) begin
              cur_r  <= '0;
              esum_r <= '0;
              isum_r <= '0;
            end
          end
        end
        S_CHECK: begin
          if (!cmp_lt) begin
            rec_kind_r  <= KIND_DONE;
            rec_start_r <= cur_r;
            state_r     <= S_EMIT;
          end else begin
            cnt_r   <= '0;
            state_r <= S_REL;
          end
        end
        S_REL: begin
          if (cnt_r < n_c) begin
            cnt_r <= cnt_r + 1'b1;
          end else begin
            cnt_r   <= '0;
            found_r <= 1'b0;
            state_r <= S_SEL;
          end
        end
        S_SEL: begin
          if (cnt_r < CNT_W'(MAX_TASKS)) begin
            if (rd_ready && (!found_r || cmp_lt)) begin
              best_idx_r   <= scan_idx;
              best_per_r   <= rd_period;
              best_stamp_r <= rd_stamp;
              best_run_r   <= rd_run;
              best_rel_r   <= rd_rel;
              found_r      <= 1'b1;
            end
            cnt_r <= cnt_r + 1'b1;
          end else if (found_r) begin
            is_idle_r <= 1'b0;
            state_r   <= S_PREP;
          end else if (n_c == '0) begin
            is_idle_r  <= 1'b1;
            best_idx_r <= '0;
            target_r   <= DUR_W'(horizon_r);
            state_r    <= S_PREP;
          end else begin
            cnt_r   <= '0;
            state_r <= S_GAP;
          end
        end
        S_GAP: begin
          if (cnt_r < n_c) begin
            if (!found_r || cmp_lt) begin
              best_idx_r <= scan_idx;
              best_rel_r <= rd_rel;
              found_r    <= 1'b1;
            end
            cnt_r <= cnt_r + 1'b1;
          end else begin
            is_idle_r <= 1'b1;
            target_r  <= DUR_W'(best_rel_r);
            state_r   <= S_PREP;
          end
        end
        S_PREP: begin
          dur_r   <= is_idle_r ? cmp_diff[DUR_W-1:0] : DUR_W'(best_run_r);
          state_r <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= PROD_W'(dur_r) *
                     PROD_W'(is_idle_r ? idle_power_r : active_power_r);
          state_r <= S_UPD;
        end
        S_UPD: begin
          esum_r <= (esum_add > EXT_W'({ETOT_W{1'b1}})) ? {ETOT_W{1'b1}}
                                                         : esum_add[ETOT_W-1:0];
          if (is_idle_r) begin
            isum_r     <= (isum_add > (DUR_W + 1)'({ITOT_W{1'b1}})) ? {ITOT_W{1'b1}}
                                                                    : isum_add[ITOT_W-1:0];
            cur_r      <= (target_r > DUR_W'(TMAX)) ? TMAX : target_r[TIME_BITS-1:0];
            rec_kind_r <= KIND_IDLE;
          end else begin
            cur_r      <= (cur_add > REL_W'(TMAX)) ? TMAX : cur_add[TIME_BITS-1:0];
            rec_kind_r <= KIND_RUN;
          end
          rec_start_r <= cur_r;
          rec_task_r  <= best_idx_r;
          rec_dur_r   <= dur_r;
          rec_e_r     <= prod_r;
          state_r     <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_user_r  <= rec_kind_r;
            out_data_r  <= {1'b0, isum_r, esum_r, slot_e,
                            rec_dur_r[OUT_TIME_W-1:0],
                            task_ext[TASK_OUT_W-1:0],
                            start_ext[OUT_TIME_W-1:0]};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `RMTS_ASSERT(a_busy_after_accept, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready)
  `RMTS_ASSERT(a_energy_grows, clk, rst_n, (state_r != S_IDLE) |=> (esum_r >= $past(esum_r)))
  `RMTS_ASSERT(a_idle_grows, clk, rst_n, (state_r != S_IDLE) |=> (isum_r >= $past(isum_r)))
  `RMTS_ASSERT(a_time_grows, clk, rst_n, (state_r != S_IDLE) |=> (cur_r >= $past(cur_r)))

endmodule

>>> sv/rmts_cmp_sub.sv
// Shared compare and subtract unit used by every scan step of the sequencer.
`timescale 1ns / 1ps
module rmts_cmp_sub #(
  parameter int W = 36
) (
  input  logic [W-1:0] op_a,
  input  logic [W-1:0] op_b,
  output logic         a_lt_b,
  output logic [W-1:0] diff
);

  logic [W:0] wide;

  assign wide   = {1'b0, op_a} - {1'b0, op_b};
  assign a_lt_b = wide[W];
  assign diff   = wide[W-1:0];

endmodule

>>> sv/rmts_task_table.sv
// Task table: periods, run times, release times, ready flags and insert stamps.
`timescale 1ns / 1ps
module rmts_task_table import rmts_pkg::*; #(
  parameter int MAX_TASKS = 8,
  parameter int TIME_BITS = 20,
  parameter int IDX_W     = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rmts_tbl_cmd_t        cmd,
  input  logic [IDX_W-1:0]     load_idx,
  input  logic [PERIOD_W-1:0]  load_period,
  input  logic [RUN_W-1:0]     load_run,
  input  logic [IDX_W-1:0]     upd_idx,
  input  logic [TIME_BITS-1:0] stamp_val,
  input  logic [TIME_BITS-1:0] rel_val,
  input  logic [IDX_W-1:0]     rd_idx,
  output logic [PERIOD_W-1:0]  rd_period,
  output logic [RUN_W-1:0]     rd_run,
  output logic [TIME_BITS-1:0] rd_rel,
  output logic                 rd_ready,
  output logic [TIME_BITS-1:0] rd_stamp
);

  logic [PERIOD_W-1:0]  period_r [MAX_TASKS];
  logic [RUN_W-1:0]     run_r    [MAX_TASKS];
  logic [TIME_BITS-1:0] rel_r    [MAX_TASKS];
  logic [TIME_BITS-1:0] stamp_r  [MAX_TASKS];
  logic [MAX_TASKS-1:0] ready_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      period_r[load_idx] <= load_period;
      run_r[load_idx]    <= load_run;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      ready_r <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        rel_r[i]   <= '0;
        stamp_r[i] <= '0;
      end
    end else if (cmd.mark_ready) begin
      ready_r[upd_idx] <= 1'b1;
      stamp_r[upd_idx] <= stamp_val;
    end else if (cmd.retire) begin
      ready_r[upd_idx] <= 1'b0;
      rel_r[upd_idx]   <= rel_val;
    end
  end

  assign rd_period = period_r[rd_idx];
  assign rd_run    = run_r[rd_idx];
  assign rd_rel    = rel_r[rd_idx];
  assign rd_ready  = ready_r[rd_idx];
  assign rd_stamp  = stamp_r[rd_idx];

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the rate-monotonic task scheduler core.
`timescale 1ns / 1ps
module testbench;
  import rmts_pkg::*;

  localparam int NUM_SLOTS = 8;
  localparam int MAX_REPORTS = 40;
  localparam longint unsigned TIME_MAX = 64'hF_FFFF;
  localparam longint unsigned ITOT_MAX = 64'hF_FFFF;
  localparam longint unsigned ETOT_MAX = 64'hFF_FFFF_FFFF;
  localparam longint unsigned SLOT_E_MAX = 64'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [19:0] start;
    logic [2:0]  task_id;
    logic [19:0] dur;
    logic [31:0] slot_e;
    logic [39:0] e_tot;
    logic [19:0] i_tot;
  } sched_rec_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // task_slot[2:0], period[18:3], run_time[34:19], zero[39:35]
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  // opcode[1:0]
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // start_time[19:0], chosen_task[22:20], duration[42:23], slot_energy[74:43],
  // energy_total[114:75], idle_total[134:115], zero[135]
  logic [OUT_DATA_W-1:0] out_tdata;
  // kind[1:0]
  logic [1:0]            out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rate_monotonic_task_scheduler_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  longint unsigned tbl_period [NUM_SLOTS];
  longint unsigned tbl_run [NUM_SLOTS];
  longint unsigned rel_time [NUM_SLOTS];
  longint unsigned stamp [NUM_SLOTS];
  bit              is_ready [NUM_SLOTS];
  longint unsigned cur_time, energy_acc, idle_acc;
  longint unsigned reg_count, reg_horizon, reg_active_pw, reg_idle_pw;

  sched_rec_t expected_records[$];
  int mismatches = 0;
  int n_requests = 0;
  int kind_seen [4] = '{0, 0, 0, 0};
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int rx_hold_cycles = 0;

  function automatic longint unsigned sat_add(longint unsigned a, longint unsigned b,
                                              longint unsigned lim);
    longint unsigned s;
    s = a + b;
    return (s > lim || s < a) ? lim : s;
  endfunction

  function automatic void clear_schedule();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      rel_time[i] = 0;
      is_ready[i] = 1'b0;
      stamp[i] = 0;
    end
    cur_time = 0;
    energy_acc = 0;
    idle_acc = 0;
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [19:0] val);
    case (idx)
      REG_TASK_COUNT:   reg_count = val[3:0];
      REG_HORIZON:      reg_horizon = val;
      REG_ACTIVE_POWER: reg_active_pw = val[11:0];
      REG_IDLE_POWER:   reg_idle_pw = val[11:0];
      default: ;
    endcase
  endfunction

  function automatic sched_rec_t schedule_step(logic [1:0] op, logic [2:0] slot,
                                               logic [15:0] per, logic [15:0] run);
    sched_rec_t r;
    int n, best, idx;
    bit found;
    longint unsigned g, bestgap, target, gap, e, dur;
    r = '0;
    n = (reg_count > NUM_SLOTS) ? NUM_SLOTS : int'(reg_count);
    found = 1'b0;
    best = 0;
    idx = 0;
    bestgap = 0;
    if (op == OP_LOAD) begin
      tbl_period[slot] = per;
      tbl_run[slot] = run;
      r.kind = KIND_ACK;
    end else if (op != OP_STEP) begin
      if (op == OP_RESTART) clear_schedule();
      r.kind = KIND_ACK;
    end else if (cur_time >= reg_horizon) begin
      r.kind = KIND_DONE;
      r.start = cur_time[19:0];
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!is_ready[i] && cur_time >= rel_time[i]) begin
          is_ready[i] = 1'b1;
          stamp[i] = cur_time;
        end
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (is_ready[i] && (!found || tbl_period[i] < tbl_period[best] ||
            (tbl_period[i] == tbl_period[best] && stamp[i] < stamp[best]))) begin
          best = i;
          found = 1'b1;
        end
      end
      r.start = cur_time[19:0];
      if (found) begin
        dur = tbl_run[best];
        e = reg_active_pw * dur;
        r.kind = KIND_RUN;
        r.task_id = 3'(best);
        r.dur = dur[19:0];
        r.slot_e = (e > SLOT_E_MAX) ? 32'hFFFF_FFFF : e[31:0];
        rel_time[best] = sat_add(rel_time[best], tbl_period[best], TIME_MAX);
        is_ready[best] = 1'b0;
        energy_acc = sat_add(energy_acc, e, ETOT_MAX);
        cur_time = sat_add(cur_time, dur, TIME_MAX);
      end else begin
        if (n == 0) begin
          target = reg_horizon;
        end else begin
          for (int i = 0; i < n; i++) begin
            g = rel_time[i] - cur_time;
            if (i == 0 || g < bestgap) begin
              bestgap = g;
              idx = i;
            end
          end
          target = rel_time[idx];
        end
        gap = (target > cur_time) ? target - cur_time : 0;
        e = gap * reg_idle_pw;
        r.kind = KIND_IDLE;
        r.task_id = 3'(idx);
        r.dur = gap[19:0];
        r.slot_e = (e > SLOT_E_MAX) ? 32'hFFFF_FFFF : e[31:0];
        idle_acc = sat_add(idle_acc, gap, ITOT_MAX);
        energy_acc = sat_add(energy_acc, e, ETOT_MAX);
        cur_time = (target > TIME_MAX) ? TIME_MAX : target;
      end
    end
    r.e_tot = energy_acc[39:0];
    r.i_tot = idle_acc[19:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  always @(posedge clk) begin : check_records
    sched_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_records.size() == 0) begin
        report_mismatch("record with no request pending");
      end else begin
        want = expected_records.pop_front();
        check_field("kind", out_tuser, want.kind);
        check_field("start_time", out_tdata[19:0], want.start);
        check_field("chosen_task", out_tdata[22:20], want.task_id);
        check_field("duration", out_tdata[42:23], want.dur);
        check_field("slot_energy", out_tdata[74:43], want.slot_e);
        check_field("energy_total", out_tdata[114:75], want.e_tot);
        check_field("idle_total", out_tdata[134:115], want.i_tot);
        kind_seen[want.kind]++;
      end
    end
  end

  // hold off for rx_hold_cycles, else stall at random
  always @(negedge clk) begin
    if (rx_hold_cycles > 0) begin
      out_tready <= 1'b0;
      rx_hold_cycles--;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  task automatic send_request(logic [1:0] op, logic [2:0] slot, logic [15:0] per,
                              logic [15:0] run);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {5'd0, run, per, slot};
    do @(posedge clk); while (!in_tready);
    expected_records.push_back(schedule_step(op, slot, per, run));
    n_requests++;
    @(negedge clk);
  endtask

  task automatic send_op(logic [1:0] op);
    send_request(op, 3'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic wait_for_idle();
    in_tvalid <= 1'b0;
    while (expected_records.size() != 0 || !in_tready) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic set_config(int unsigned tc, int unsigned hz, int unsigned ap,
                            int unsigned ip);
    write_reg(REG_TASK_COUNT, 20'(tc));
    write_reg(REG_HORIZON, 20'(hz));
    write_reg(REG_ACTIVE_POWER, 20'(ap));
    write_reg(REG_IDLE_POWER, 20'(ip));
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_request(OP_LOAD, 3'd0, 16'd400, 16'd300);
    repeat (6) send_op(OP_STEP);
    send_op(OP_NOP);
  endtask

  task automatic test_extreme_values();
    wait_for_idle();
    set_config(2, 32'(TIME_MAX), 4095, 4095);
    send_request(OP_LOAD, 3'd0, 16'hFFFF, 16'hFFFF);
    send_request(OP_LOAD, 3'd1, 16'd0, 16'd0);
    send_op(OP_RESTART);
    repeat (2) send_op(OP_STEP);
    send_request(OP_LOAD, 3'd1, 16'd1, 16'hFFFF);
    repeat (2) send_op(OP_STEP);
  endtask

  task automatic test_equal_periods();
    wait_for_idle();
    set_config(2, 60, 3, 5);
    send_request(OP_LOAD, 3'd0, 16'd10, 16'd7);
    send_request(OP_LOAD, 3'd1, 16'd10, 16'd7);
    send_op(OP_RESTART);
    repeat (6) send_op(OP_STEP);
  endtask

  task automatic test_task_count_edges();
    for (int s = 2; s < NUM_SLOTS; s++)
      send_request(OP_LOAD, 3'(s), 16'(40 * s), 16'(5 + 3 * s));
    wait_for_idle();
    set_config(0, 500, 100, 7);
    send_op(OP_RESTART);
    repeat (2) send_op(OP_STEP);
    wait_for_idle();
    set_config(12, 3000, 4095, 0);
    send_op(OP_RESTART);
    repeat (3) send_op(OP_STEP);
    wait_for_idle();
    set_config(8, 3000, 1, 1);
    send_op(OP_RESTART);
    repeat (2) send_op(OP_STEP);
    // drop the count while most tasks are still ready
    wait_for_idle();
    set_config(1, 3000, 1, 1);
    repeat (4) send_op(OP_STEP);
  endtask

  task automatic test_backpressure();
    wait_for_idle();
    set_config(8, 5000, 50, 2);
    send_op(OP_RESTART);
    rx_hold_cycles = 400;
    repeat (20) send_op(OP_STEP);
  endtask

  task automatic run_episode();
    int unsigned tc, hz, ap, ip, pmax, per, run, steps, r;
    bit big;
    tc = ($urandom_range(0, 99) < 85) ? $urandom_range(1, NUM_SLOTS) : $urandom_range(0, 15);
    big = ($urandom_range(0, 9) == 0);
    if (big) hz = 32'(TIME_MAX);
    else if ($urandom_range(0, 4) == 0) hz = $urandom_range(1, 60000);
    else hz = $urandom_range(40, 4000);
    ap = ($urandom_range(0, 3) == 0) ? 4095 : $urandom_range(0, 4095);
    ip = ($urandom_range(0, 3) == 0) ? 4095 : $urandom_range(0, 4095);
    pmax = hz / 3 + 2;
    if (pmax > 65535) pmax = 65535;
    steps = 0;
    wait_for_idle();
    set_config(tc, hz, ap, ip);
    repeat ($urandom_range(1, NUM_SLOTS)) begin
      if (big) begin
        per = $urandom_range(30000, 65535);
        run = $urandom_range(20000, 65535);
      end else begin
        per = ($urandom_range(0, 49) == 0) ? 0 : $urandom_range(1, pmax);
        run = ($urandom_range(0, 99) < 85) ? $urandom_range(0, per / 2 + 1)
                                            : $urandom_range(0, per * 2 + 1);
        if (run > 65535) run = 65535;
      end
      send_request(OP_LOAD, 3'($urandom), 16'(per), 16'(run));
    end
    if ($urandom_range(0, 4) != 0) send_op(OP_RESTART);
    while (cur_time < reg_horizon && steps < 120) begin
      r = $urandom_range(0, 99);
      if (r < 90) send_op(OP_STEP);
      else if (r < 94) send_op(OP_NOP);
      else if (r < 97)
        send_request(OP_LOAD, 3'($urandom), 16'($urandom_range(0, pmax)),
                     16'($urandom_range(0, pmax)));
      else send_op(OP_RESTART);
      steps++;
    end
    repeat ($urandom_range(1, 2)) send_op(OP_STEP);
  endtask

  task automatic test_random_schedules();
    int target;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 68; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 68; end
        default: begin snd_idle_pct = 9; rcv_stall_pct = 9; end
      endcase
      target = n_requests + 320;
      while (n_requests < target) run_episode();
    end
  endtask

  task automatic finish_run();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (expected_records.size() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (40) @(negedge clk);
    if (expected_records.size() != 0)
      report_mismatch($sformatf("%0d records never arrived", expected_records.size()));
    $display("Sent %0d requests; checked %0d runs, %0d idle gaps, %0d finished, %0d acks.",
             n_requests, kind_seen[KIND_RUN], kind_seen[KIND_IDLE], kind_seen[KIND_DONE],
             kind_seen[KIND_ACK]);
    $display("Task counts 0 to 15, horizons up to the time limit, four idle/stall mixes.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  endtask

  initial begin
    reg_count = TASK_COUNT_RST;
    reg_horizon = HORIZON_RST;
    reg_active_pw = 0;
    reg_idle_pw = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tbl_period[i] = 0;
      tbl_run[i] = 0;
    end
    clear_schedule();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_extreme_values();
    test_equal_periods();
    test_task_count_edges();
    test_backpressure();
    test_random_schedules();
    finish_run();
  end

  initial begin
    #(20_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/rmts_pkg.sv
sv/rmts_cmp_sub.sv
sv/rmts_task_table.sv
sv/rate_monotonic_task_scheduler_core.sv
tb/testbench.sv
